[sv/bdl_pkg.sv]
package bdl_pkg;

	localparam int unsigned LINES_W   = 4;
	localparam int unsigned AGE_W     = 8;
	localparam int unsigned MS_W      = 32;
	localparam int unsigned S_DATA_W  = 48;
	localparam int unsigned M_DATA_W  = 48;

	localparam logic [AGE_W-1:0] STABLE_MS_RESET = AGE_W'(2);
	localparam logic [AGE_W-1:0] AGE_MAX         = '1;
	localparam logic [MS_W-1:0]  IDLE_MAX        = '1;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_SET    = 2'd1,
		OP_BREAK  = 2'd2,
		OP_DRAIN  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic               ms_tick;
		logic [LINES_W-1:0] raw_lines;
		logic [LINES_W-1:0] latch_mask;
		logic [MS_W-1:0]    latch_ms;
	} item_t;

	typedef struct packed {
		logic [LINES_W-1:0] clean_buttons;
		logic [LINES_W-1:0] drive_mask;
		logic               latch_on;
		logic               timed_out;
		logic [MS_W-1:0]    held_ms;
	} result_t;

endpackage

[sv/bdl_in_stage.sv]
module bdl_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bdl_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [1:0]                    s_tuser,
	input  logic                          advance,
	output logic                          valid_s1,
	output bdl_pkg::item_t                item_s1
);

	logic accept;

	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// unpack tdata: ms_tick, raw_lines, latch_mask, latch_ms from bit 0 up
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op         <= bdl_pkg::op_t'(s_tuser);
			item_s1.ms_tick    <= s_tdata[0];
			item_s1.raw_lines  <= s_tdata[4:1];
			item_s1.latch_mask <= s_tdata[8:5];
			item_s1.latch_ms   <= s_tdata[40:9];
		end
	end

endmodule

[sv/bdl_core.sv]
module bdl_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bdl_pkg::AGE_W-1:0]    cfg_wdata,
	input  logic                         fire,
	input  bdl_pkg::item_t               item,
	output bdl_pkg::result_t             res
);

	logic [bdl_pkg::AGE_W-1:0]   stable_ms_q;
	logic [bdl_pkg::LINES_W-1:0] prev_q, prev_n;
	logic [bdl_pkg::AGE_W-1:0]   stable_age_q, stable_age_n, age_t;
	logic                        drain_q, drain_n;
	logic [bdl_pkg::LINES_W-1:0] held_q, held_n;
	logic [bdl_pkg::MS_W-1:0]    limit_q, limit_n;
	logic [bdl_pkg::MS_W-1:0]    idle_q, idle_n, idle_t;
	logic [bdl_pkg::MS_W:0]      sum;
	logic [bdl_pkg::LINES_W-1:0] buttons;
	logic [bdl_pkg::LINES_W-1:0] clean;
	logic                        timed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_ms_q <= bdl_pkg::STABLE_MS_RESET;
		end else if (cfg_we) begin
			stable_ms_q <= cfg_wdata;
		end
	end

	always_comb begin
		// age counters on the tick, saturating
		age_t  = (item.ms_tick && stable_age_q != bdl_pkg::AGE_MAX) ?
		         stable_age_q + 1'b1 : stable_age_q;
		idle_t = (item.ms_tick && idle_q != bdl_pkg::IDLE_MAX) ? idle_q + 1'b1 : idle_q;

		prev_n       = prev_q;
		stable_age_n = age_t;
		drain_n      = drain_q;
		held_n       = held_q;
		limit_n      = limit_q;
		idle_n       = idle_t;
		clean        = '0;
		timed        = 1'b0;
		buttons      = '0;
		sum          = {1'b0, limit_q} + {1'b0, item.latch_ms};

		case (item.op)
			bdl_pkg::OP_SAMPLE: begin
				if (held_q != '0 && idle_t > limit_q) begin
					timed  = 1'b1;
					held_n = '0;
				end
				prev_n = item.raw_lines;
				if (!(drain_q && item.raw_lines != '0)) begin
					drain_n = 1'b0;
					buttons = (prev_q != '0 && prev_q != item.raw_lines) ?
					          '0 : item.raw_lines;
					if (buttons == '0) begin
						stable_age_n = '0;
					end
					clean = (stable_age_n < stable_ms_q) ? '0 : buttons;
				end
			end
			bdl_pkg::OP_SET: begin
				if (held_q == item.latch_mask) begin
					// extend only when the sum neither wraps nor stays put
					if (!sum[bdl_pkg::MS_W] && item.latch_ms != '0) begin
						limit_n = sum[bdl_pkg::MS_W-1:0];
					end
				end else begin
					held_n  = item.latch_mask;
					limit_n = item.latch_ms;
				end
				idle_n = '0;
			end
			bdl_pkg::OP_BREAK: begin
				held_n = '0;
			end
			bdl_pkg::OP_DRAIN: begin
				drain_n = 1'b1;
			end
			default: begin
				drain_n = drain_q;
			end
		endcase

		res.clean_buttons = clean;
		res.drive_mask    = held_n;
		res.latch_on      = held_n != '0;
		res.timed_out     = timed;
		res.held_ms       = limit_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			stable_age_q <= '0;
			drain_q      <= 1'b0;
			held_q       <= '0;
			limit_q      <= '0;
			idle_q       <= '0;
		end else if (fire) begin
			prev_q       <= prev_n;
			stable_age_q <= stable_age_n;
			drain_q      <= drain_n;
			held_q       <= held_n;
			limit_q      <= limit_n;
			idle_q       <= idle_n;
		end
	end

	a_timeout_drops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.timed_out |=> held_q == '0)
		else $error("timeout left the latch held");

	a_set_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == bdl_pkg::OP_SET |=> idle_q == '0)
		else $error("set latch did not restart idle time");

	a_press_is_stable: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.clean_buttons != '0 |=>
		stable_age_q >= $past(stable_ms_q) && !drain_q)
		else $error("press reported before it was stable");

endmodule

[sv/bdl_out_stage.sv]
module bdl_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  bdl_pkg::result_t              res,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bdl_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          advance
);

	logic             valid_q;
	bdl_pkg::result_t res_q;

	assign advance  = !valid_q || m_tready;
	assign m_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tdata = {6'd0, res_q.held_ms, res_q.timed_out, res_q.latch_on,
	                  res_q.drive_mask, res_q.clean_buttons};

endmodule

[sv/button_debounce_with_timed_latch.sv]
// Four-line button qualifier with a timed output latch. Each item may carry a
// millisecond tick and one operation (sample, set latch, break latch, start
// drain, given in s_tuser); each gives exactly one result. One item can be
// taken every clock cycle while the receiver keeps up. The input register
// holds an accepted item; when it moves on, all state and the result
// register are updated at the same clock edge, and the result is held on
// m_tdata until taken. s_tready falls only while both registers hold items
// and m_tready is low. stable_ms resets to 2; the user must write it through
// cfg_we and cfg_wdata while no item is in flight, not enforced by the block.
module button_debounce_with_timed_latch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bdl_pkg::AGE_W-1:0]     cfg_wdata,   // stable_ms
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// ms_tick, raw_lines[3:0], latch_mask[3:0], latch_ms[31:0], zero fill
	input  logic [bdl_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic [1:0]                    s_tuser,     // op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// clean_buttons[3:0], drive_mask[3:0], latch_on, timed_out, held_ms[31:0],
	// zero fill
	output logic [bdl_pkg::M_DATA_W-1:0]  m_tdata
);

	logic             advance;
	logic             valid_s1;
	logic             fire;
	bdl_pkg::item_t   item_s1;
	bdl_pkg::result_t res;

	assign fire = valid_s1 && advance;

	bdl_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bdl_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item      (item_s1),
		.res       (res)
	);

	bdl_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.advance  (advance)
	);

endmodule

[sim/button_debounce_with_timed_latch_test.sv]
`timescale 1ns / 1ps

module button_debounce_with_timed_latch_test;
	import bdl_pkg::*;

	localparam int unsigned SINK_HOLD_CYCLES = 300;
	localparam longint unsigned LIMIT_CYCLES = 1_500_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [AGE_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;

	// predictor state and its copy of the register
	logic [AGE_W-1:0]     stable_ms_cfg = STABLE_MS_RESET;
	logic [LINES_W-1:0]   prev_lines = '0;
	logic [AGE_W-1:0]     press_age = '0;
	logic                 draining = 1'b0;
	logic [LINES_W-1:0]   held_lines = '0;
	logic [MS_W-1:0]      hold_limit_ms = '0;
	logic [MS_W-1:0]      idle_ms = '0;

	result_t              result_due_q[$];
	int                   fail_count = 0;
	bit                   calm = 1'b0;
	bit                   hold_sink = 1'b0;

	button_debounce_with_timed_latch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * 10);
		$display("DONE: errors detected");
		$finish;
	end

	// Tick ageing, then one operation; returns the result this item must produce.
	function automatic result_t step_qualifier_latch(input item_t it);
		result_t          r;
		logic [LINES_W-1:0] prior;
		logic [LINES_W-1:0] btn;
		logic [MS_W:0]    sum;
		r = '0;
		if (it.ms_tick) begin
			if (press_age != AGE_MAX) press_age++;
			if (idle_ms != IDLE_MAX) idle_ms++;
		end
		case (it.op)
			OP_SAMPLE: begin
				if (held_lines != '0 && idle_ms > hold_limit_ms) begin
					held_lines = '0;
					r.timed_out = 1'b1;
				end
				prior = prev_lines;
				prev_lines = it.raw_lines;
				if (draining && it.raw_lines != '0) begin
					btn = '0;
				end else begin
					draining = 1'b0;
					btn = it.raw_lines;
					if (prior != '0 && prior != it.raw_lines) btn = '0;
					if (btn == '0) press_age = '0;
					if (press_age < stable_ms_cfg) btn = '0;
				end
				r.clean_buttons = btn;
			end
			OP_SET: begin
				if (held_lines == it.latch_mask) begin
					// skip the extension on wrap or when nothing is added
					sum = {1'b0, hold_limit_ms} + {1'b0, it.latch_ms};
					if (!sum[MS_W] && it.latch_ms != '0) hold_limit_ms = sum[MS_W-1:0];
				end else begin
					held_lines = it.latch_mask;
					hold_limit_ms = it.latch_ms;
				end
				idle_ms = '0;
			end
			OP_BREAK: held_lines = '0;
			default: draining = 1'b1;
		endcase
		r.drive_mask = held_lines;
		r.latch_on = (held_lines != '0);
		r.held_ms = hold_limit_ms;
		return r;
	endfunction

	function automatic item_t make_item(input op_t op, input logic tick,
			input logic [LINES_W-1:0] raw, input logic [LINES_W-1:0] mask,
			input logic [MS_W-1:0] ms);
		item_t it;
		it.op = op;
		it.ms_tick = tick;
		it.raw_lines = raw;
		it.latch_mask = mask;
		it.latch_ms = ms;
		return it;
	endfunction

	function automatic int idle_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [MS_W-1:0] rand_latch_ms();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return MS_W'($urandom_range(0, 12));
		if (r < 85) return MS_W'($urandom);
		if (r < 95) return IDLE_MAX - MS_W'($urandom_range(0, 20));
		return '0;
	endfunction

	// Offer one item and hold it until taken; predict at acceptance.
	task automatic send_item(input item_t it);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'b0, it.latch_ms, it.latch_mask, it.raw_lines, it.ms_tick};
		s_tuser <= it.op;
		do @(posedge clk); while (!s_tready);
		result_due_q.push_back(step_qualifier_latch(it));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (result_due_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_stable_ms(input logic [AGE_W-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		stable_ms_cfg = value;
	endtask

	// Receiver pacing: random stalls, or one long hold-off on request.
	initial begin : sink_pacing
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
				hold_sink = 1'b0;
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < 15) begin
				m_tready <= 1'b0;
				repeat (idle_gap() + 1) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (result_due_q.size() == 0) begin
				$error("unexpected result item: m_tdata=%h", m_tdata);
				fail_count++;
			end else begin
				want = result_due_q.pop_front();
				if (m_tdata[3:0] !== want.clean_buttons) begin
					$error("clean_buttons: expected %0h, got %0h", want.clean_buttons,
						m_tdata[3:0]);
					fail_count++;
				end
				if (m_tdata[7:4] !== want.drive_mask) begin
					$error("drive_mask: expected %0h, got %0h", want.drive_mask, m_tdata[7:4]);
					fail_count++;
				end
				if (m_tdata[8] !== want.latch_on) begin
					$error("latch_on: expected %0b, got %0b", want.latch_on, m_tdata[8]);
					fail_count++;
				end
				if (m_tdata[9] !== want.timed_out) begin
					$error("timed_out: expected %0b, got %0b", want.timed_out, m_tdata[9]);
					fail_count++;
				end
				if (m_tdata[41:10] !== want.held_ms) begin
					$error("held_ms: expected %0h, got %0h", want.held_ms, m_tdata[41:10]);
					fail_count++;
				end
			end
		end
	end

	// Default stable_ms of 2: press qualification and glitch rejection.
	task automatic test_press_qualify();
		send_item(make_item(OP_SAMPLE, 1'b0, 4'h0, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'h5, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'h5, 4'hF, '1));
		send_item(make_item(OP_SAMPLE, 1'b0, 4'h5, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'hF, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'hF, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'hF, 4'h0, '0));
	endtask

	task automatic test_drain();
		send_item(make_item(OP_DRAIN, 1'b1, 4'hF, 4'hF, '1));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'hA, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'hA, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b0, 4'h0, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'hA, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'hA, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'hA, 4'h0, '0));
	endtask

	// Extension with wrap and zero add, break, zero mask, timeout.
	task automatic test_latch();
		send_item(make_item(OP_SET, 1'b0, 4'h0, 4'hF, 32'hFFFF_FFF0));
		send_item(make_item(OP_SET, 1'b1, 4'h0, 4'hF, 32'h0000_0100));
		send_item(make_item(OP_SET, 1'b0, 4'h0, 4'hF, 32'h0));
		send_item(make_item(OP_SET, 1'b0, 4'h0, 4'hF, 32'h0000_000F));
		send_item(make_item(OP_BREAK, 1'b1, 4'hF, 4'hF, '1));
		send_item(make_item(OP_SET, 1'b0, 4'h0, 4'h0, 32'h5));
		send_item(make_item(OP_SET, 1'b0, 4'h0, 4'h3, 32'h1));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'h0, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'h0, 4'h0, '0));
		send_item(make_item(OP_SET, 1'b0, 4'h0, 4'h0, 32'h2));
		send_item(make_item(OP_SET, 1'b1, 4'h0, 4'h6, 32'h7));
		send_item(make_item(OP_SET, 1'b0, 4'h0, 4'h0, 32'hFFFF_FFFF));
		send_item(make_item(OP_SET, 1'b0, 4'h0, 4'h9, 32'h3));
		send_item(make_item(OP_BREAK, 1'b0, 4'h0, 4'h0, '0));
	endtask

	// stable_ms at its top end drives the press age into saturation; then stable_ms of 1.
	task automatic test_stable_extremes();
		write_stable_ms(8'd255);
		repeat (262) send_item(make_item(OP_SAMPLE, 1'b1, 4'h9, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b0, 4'h9, 4'h0, '0));
		write_stable_ms(8'd1);
		send_item(make_item(OP_SAMPLE, 1'b0, 4'h0, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b1, 4'h6, 4'h0, '0));
		send_item(make_item(OP_SAMPLE, 1'b0, 4'h6, 4'h0, '0));
	endtask

	task automatic run_random_phase(input int n_items);
		int sent;
		int kind;
		int len;
		logic [LINES_W-1:0] lines;
		logic [LINES_W-1:0] mask;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 29) == 0) calm = ~calm;
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				// press burst, mostly steady, now and then a glitch
				lines = ($urandom_range(0, 9) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
				len = $urandom_range(1, int'(stable_ms_cfg) + 4);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 9) == 0)
						send_item(make_item(OP_SAMPLE, 1'($urandom), 4'($urandom),
							4'($urandom), MS_W'($urandom)));
					else
						send_item(make_item(OP_SAMPLE, $urandom_range(0, 9) < 7, lines,
							4'($urandom), MS_W'($urandom)));
				end
				sent += len;
			end else if (kind < 60) begin
				// latch, then watch it age towards release
				mask = $urandom_range(0, 1) ? held_lines : 4'($urandom);
				send_item(make_item(OP_SET, 1'($urandom), 4'($urandom), mask,
					rand_latch_ms()));
				len = $urandom_range(1, 12);
				for (int k = 0; k < len; k++)
					send_item(make_item(OP_SAMPLE, $urandom_range(0, 9) < 8,
						$urandom_range(0, 1) ? 4'h0 : 4'($urandom), 4'($urandom),
						MS_W'($urandom)));
				sent += len + 1;
			end else if (kind < 70) begin
				send_item(make_item(OP_DRAIN, 1'($urandom), 4'($urandom), 4'($urandom),
					MS_W'($urandom)));
				len = $urandom_range(0, 4);
				for (int k = 0; k < len; k++)
					send_item(make_item(OP_SAMPLE, 1'($urandom), 4'($urandom_range(1, 15)),
						4'h0, '0));
				send_item(make_item(OP_SAMPLE, 1'($urandom), 4'h0, 4'h0, '0));
				sent += len + 2;
			end else if (kind < 75) begin
				send_item(make_item(OP_BREAK, 1'($urandom), 4'($urandom), 4'($urandom),
					MS_W'($urandom)));
				sent++;
			end else begin
				send_item(make_item(op_t'($urandom_range(0, 3)), 1'($urandom),
					4'($urandom), 4'($urandom), MS_W'($urandom)));
				sent++;
			end
		end
		calm = 1'b0;
	endtask

	task automatic test_random();
		write_stable_ms(8'd1);
		run_random_phase(220);
		write_stable_ms(8'd3);
		run_random_phase(220);
		write_stable_ms(8'($urandom_range(1, 6)));
		run_random_phase(220);
		write_stable_ms(8'd2);
		run_random_phase(220);
	endtask

	// Receiver parks while the sender keeps offering, so the input must stall.
	task automatic test_backpressure();
		calm = 1'b1;
		hold_sink = 1'b1;
		repeat (40)
			send_item(make_item(op_t'($urandom_range(0, 3)), 1'($urandom),
				4'($urandom), 4'($urandom), rand_latch_ms()));
		calm = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_press_qualify();
		test_drain();
		test_latch();
		test_stable_extremes();
		test_random();
		test_backpressure();
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
